>>> hw/rtl/ste_pkg.sv
`timescale 1ns / 1ps
package ste_pkg;

  localparam int TICK_BITS     = 32;
  localparam int TAG_BITS      = 16;
  localparam int ID_W          = 5;
  localparam int OP_W          = 2;
  localparam int ST_W          = 3;
  localparam int WAIT_W        = 31;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int TIMERS_DEF    = 32;
  localparam int MAX_FIRES_DEF = 32;
  localparam int IN_TDATA_W    = 152;
  localparam int OUT_TDATA_W   = 152;

  localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
  localparam logic [OP_W-1:0] OP_RESCHED = 2'd2;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd3;

  localparam logic [ST_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [ST_W-1:0] ST_DELETED  = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_TIMER = 3'd2;
  localparam logic [ST_W-1:0] ST_MISMATCH = 3'd3;
  localparam logic [ST_W-1:0] ST_RESCHED  = 3'd4;
  localparam logic [ST_W-1:0] ST_FIRED    = 3'd5;
  localparam logic [ST_W-1:0] ST_WAIT     = 3'd6;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WAIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CATCHUP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_WAIT = 2'd2;

  localparam logic [CFG_W-1:0] RST_MIN_WAIT  = 16'd50;
  localparam logic [CFG_W-1:0] RST_CATCHUP   = 16'd1000;
  localparam logic [CFG_W-1:0] RST_IDLE_WAIT = 16'd1000;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [TICK_BITS-1:0] tick;
    logic [TICK_BITS-1:0] interval;
    logic [ID_W-1:0]      tid;
    logic [TAG_BITS-1:0]  tag;
    logic [31:0]          uid;
    logic [31:0]          ud;
  } cmd_t;

  typedef struct packed {
    logic [TICK_BITS-1:0] dl;
    logic [TICK_BITS-1:0] per;
    logic [TAG_BITS-1:0]  tag;
    logic [31:0]          uid;
    logic [31:0]          ud;
  } rec_t;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [ID_W-1:0]      id;
    logic [TICK_BITS-1:0] tick;
    logic [TAG_BITS-1:0]  tag;
    logic [31:0]          uid;
    logic [31:0]          ud;
    logic [WAIT_W-1:0]    wait_ticks;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_wait;
    logic [CFG_W-1:0] catchup;
    logic [CFG_W-1:0] idle_wait;
  } cfg_t;

endpackage

>>> hw/rtl/sorted_deadline_timer_engine_unit.sv
`timescale 1ns / 1ps
// Sorted deadline timer engine.
// in_*  : command requests; tuser = operation (add, delete, reschedule,
//         advance), tdata = timer fields. A two-entry command queue lets
//         requests be taken while the engine is busy.
// out_* : results; tuser = status, tlast marks the final result of a request.
//         An advance returns one result per reported firing, then a wait.
// cfg_* : register writes (min_wait, catchup_limit, idle_wait), always ready.
// Results leave through an output register. The engine handles one request at a
// time through its timer record memory and the shift-insert sorted list.
// Reset clears the sorted list, free list and index allocator; the
// registers return to 50 / 1000 / 1000. A stalled out_tready holds the
// result and the engine waits; requests keep queuing until the queue fills.
module sorted_deadline_timer_engine_unit #(
  parameter int TIMERS    = ste_pkg::TIMERS_DEF,
  parameter int MAX_FIRES = ste_pkg::MAX_FIRES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tick_value, interval, timer_id, owner_tag, user_id, user_data, pad
  input  logic [ste_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation
  input  logic [ste_pkg::OP_W-1:0]        in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // timer_id_res, event_tick, owner_tag_res, user_id_res, user_data_res,
  // wait_ticks, pad
  output logic [ste_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [ste_pkg::ST_W-1:0]        out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ste_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ste_pkg::CFG_W-1:0]       cfg_data
);
  import ste_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;
  logic cmd_valid, cmd_ready;
  res_t res;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_WAIT:  cfg_nxt.min_wait  = cfg_data;
        CFG_CATCHUP:   cfg_nxt.catchup   = cfg_data;
        CFG_IDLE_WAIT: cfg_nxt.idle_wait = cfg_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_wait  <= RST_MIN_WAIT;
      cfg_r.catchup   <= RST_CATCHUP;
      cfg_r.idle_wait <= RST_IDLE_WAIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ste_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  ste_back #(
    .TIMERS    (TIMERS),
    .MAX_FIRES (MAX_FIRES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cfg       (cfg_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {4'b0, res.wait_ticks, res.ud, res.uid, res.tag, res.tick, res.id};
  assign out_tuser = res.status;
  assign out_tlast = res.last;

`ifndef SYNTHESIS
  a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_FIRED)) |-> !out_tlast)
    else $error("fired result marked last");
  a_wait_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_WAIT)) |-> out_tlast)
    else $error("wait result not marked last");
  a_added_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_ADDED)) |-> (out_tlast && (out_tdata[147:5] == '0)))
    else $error("added result malformed");
`endif

endmodule

>>> hw/rtl/ste_front.sv
`timescale 1ns / 1ps
module ste_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ste_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [ste_pkg::OP_W-1:0]         in_tuser,
  output ste_pkg::cmd_t                    cmd,
  output logic                             cmd_valid,
  input  logic                             cmd_ready
);
  import ste_pkg::*;

  cmd_t       fifo_r [2];
  cmd_t       dec;
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  always_comb begin
    dec.op       = in_tuser;
    dec.tick     = in_tdata[31:0];
    dec.interval = in_tdata[63:32];
    dec.tid      = in_tdata[68:64];
    dec.tag      = in_tdata[84:69];
    dec.uid      = in_tdata[116:85];
    dec.ud       = in_tdata[148:117];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = fifo_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/ste_sortq.sv
`timescale 1ns / 1ps
module ste_sortq #(
  parameter  int TIMERS = ste_pkg::TIMERS_DEF,
  localparam int IDX_W  = (TIMERS > 1) ? $clog2(TIMERS) : 1,
  localparam int CNT_W  = $clog2(TIMERS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ins_en,
  input  logic                          pop_en,
  input  logic                          rem_en,
  input  logic [IDX_W-1:0]              key_idx,
  input  logic [ste_pkg::TICK_BITS-1:0] key_dl,
  output logic [IDX_W-1:0]              head_idx,
  output logic [ste_pkg::TICK_BITS-1:0] head_dl,
  output logic [CNT_W-1:0]              cnt,
  output logic                          found
);
  import ste_pkg::*;

  // cell 0 is the next timer to fire
  logic [IDX_W-1:0]     cell_idx_r [TIMERS];
  logic [TICK_BITS-1:0] cell_dl_r  [TIMERS];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TIMERS-1:0]    lt, match;
  logic [TIMERS-1:0]    lt_hi, match_lo;
  logic                 ins_ok, rem_ok;

  assign ins_ok   = ins_en && (cnt_r < CNT_W'(TIMERS));
  assign found    = |match;
  assign rem_ok   = rem_en && found;
  assign head_idx = cell_idx_r[0];
  assign head_dl  = cell_dl_r[0];
  assign cnt      = cnt_r;

  // lt_hi[k]: some cell at k or above precedes the key
  // match_lo[k]: the matching cell sits at k or below
  always_comb begin
    lt_hi[TIMERS-1] = lt[TIMERS-1];
    for (int j = TIMERS - 2; j >= 0; j--) begin
      lt_hi[j] = lt_hi[j+1] | lt[j];
    end
    match_lo[0] = match[0];
    for (int j = 1; j < TIMERS; j++) begin
      match_lo[j] = match_lo[j-1] | match[j];
    end
  end

  for (genvar k = 0; k < TIMERS; k++) begin : g_cell
    logic [TICK_BITS-1:0] diff;
    logic                 vld, prv_lt;
    logic [IDX_W-1:0]     up_idx, dn_idx;
    logic [TICK_BITS-1:0] up_dl, dn_dl;

    assign vld      = CNT_W'(k) < cnt_r;
    assign diff     = key_dl - cell_dl_r[k];
    assign lt[k]    = vld && ((!diff[TICK_BITS-1] && (diff != '0)) ||
                      ((diff == '0) && (cell_idx_r[k] < key_idx)));
    assign match[k] = vld && (cell_idx_r[k] == key_idx);

    if (k == 0) begin : g_first
      assign prv_lt = 1'b1;
      assign dn_idx = cell_idx_r[k];
      assign dn_dl  = cell_dl_r[k];
    end else begin : g_mid
      assign prv_lt = lt_hi[k-1];
      assign dn_idx = cell_idx_r[k-1];
      assign dn_dl  = cell_dl_r[k-1];
    end

    if (k == TIMERS - 1) begin : g_top
      assign up_idx = cell_idx_r[k];
      assign up_dl  = cell_dl_r[k];
    end else begin : g_low
      assign up_idx = cell_idx_r[k+1];
      assign up_dl  = cell_dl_r[k+1];
    end

    always_ff @(posedge clk) begin
      if (ins_ok) begin
        if (!lt_hi[k]) begin
          cell_idx_r[k] <= prv_lt ? key_idx : dn_idx;
          cell_dl_r[k]  <= prv_lt ? key_dl : dn_dl;
        end
      end else if (pop_en || (rem_ok && match_lo[k])) begin
        cell_idx_r[k] <= up_idx;
        cell_dl_r[k]  <= up_dl;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ins_ok) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop_en || rem_ok) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/ste_back.sv
`timescale 1ns / 1ps
module ste_back #(
  parameter  int TIMERS    = ste_pkg::TIMERS_DEF,
  parameter  int MAX_FIRES = ste_pkg::MAX_FIRES_DEF,
  localparam int IDX_W     = (TIMERS > 1) ? $clog2(TIMERS) : 1,
  localparam int CNT_W     = $clog2(TIMERS + 1),
  localparam int FIRE_W    = $clog2(MAX_FIRES + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ste_pkg::cmd_t  cmd,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  ste_pkg::cfg_t  cfg,
  output logic           out_valid,
  input  logic           out_ready,
  output ste_pkg::res_t  out_res
);
  import ste_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ADD_IDX = 4'd1;
  localparam logic [3:0] S_ADD_WR  = 4'd2;
  localparam logic [3:0] S_DEL     = 4'd3;
  localparam logic [3:0] S_RES     = 4'd4;
  localparam logic [3:0] S_RES_INS = 4'd5;
  localparam logic [3:0] S_ADV     = 4'd6;
  localparam logic [3:0] S_FIRE    = 4'd7;
  localparam logic [3:0] S_RELOAD  = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;

  logic [3:0]           state_r, state_nxt, ret_r, ret_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [TICK_BITS-1:0] dl_r, dl_nxt, rep_r, rep_nxt, nextmin_r, nextmin_nxt;
  logic                 late_r, late_nxt;
  logic [FIRE_W-1:0]    taken_r, taken_nxt;
  res_t                 res_r, res_nxt, out_res_r, out_res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]     free_cnt_r, free_cnt_nxt, fresh_r, fresh_nxt;

  rec_t                 rec_mem [TIMERS];
  rec_t                 rd_r, rec_wd;
  logic                 rec_we, rec_re;
  logic [IDX_W-1:0]     rec_wa, rec_ra;
  logic [IDX_W-1:0]     free_mem [TIMERS];
  logic [IDX_W-1:0]     free_rd_r, free_ra, free_wa;
  logic                 free_we, free_re;

  logic                 sq_ins, sq_pop, sq_rem, sq_found;
  logic [IDX_W-1:0]     key_idx, head_idx;
  logic [TICK_BITS-1:0] key_dl, head_dl;
  logic [CNT_W-1:0]     sq_cnt;

  logic [TICK_BITS-1:0]     diff, ndl;
  logic [TICK_BITS:0]       late_sum;
  logic [CNT_W-1:0]         fc_m1;
  logic [IDX_W+ID_W-1:0]    tid_ext, id_ext;
  logic                     tid_ok;

  ste_sortq #(.TIMERS(TIMERS)) u_sortq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ins_en   (sq_ins),
    .pop_en   (sq_pop),
    .rem_en   (sq_rem),
    .key_idx  (key_idx),
    .key_dl   (key_dl),
    .head_idx (head_idx),
    .head_dl  (head_dl),
    .cnt      (sq_cnt),
    .found    (sq_found)
  );

  function automatic logic [WAIT_W-1:0] clamp_wait(logic [TICK_BITS-1:0] v,
                                                   logic [CFG_W-1:0] mn);
    logic signed [TICK_BITS:0] vs, ms;
    vs = {v[TICK_BITS-1], v};
    ms = (TICK_BITS + 1)'(mn);
    if (vs < ms) begin
      return WAIT_W'(mn);
    end
    return v[WAIT_W-1:0];
  endfunction

  function automatic res_t mk_res(logic [ST_W-1:0] st);
    res_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  assign tid_ext   = (IDX_W + ID_W)'(cmd.tid);
  assign tid_ok    = (CNT_W + ID_W)'(cmd.tid) < (CNT_W + ID_W)'(fresh_r);
  assign id_ext    = (IDX_W + ID_W)'(idx_r);
  assign fc_m1     = free_cnt_r - CNT_W'(1);
  assign diff      = head_dl - cmd_r.tick;
  assign late_sum  = {diff[TICK_BITS-1], diff} + (TICK_BITS + 1)'(cfg.catchup);
  assign ndl       = rep_r + rd_r.per;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    dl_nxt        = dl_r;
    rep_nxt       = rep_r;
    late_nxt      = late_r;
    nextmin_nxt   = nextmin_r;
    taken_nxt     = taken_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    free_cnt_nxt  = free_cnt_r;
    fresh_nxt     = fresh_r;
    cmd_ready     = 1'b0;
    rec_we        = 1'b0;
    rec_wa        = idx_r;
    rec_wd        = rd_r;
    rec_re        = 1'b0;
    rec_ra        = head_idx;
    free_we       = 1'b0;
    free_wa       = free_cnt_r[IDX_W-1:0];
    free_re       = 1'b0;
    free_ra       = fc_m1[IDX_W-1:0];
    sq_ins        = 1'b0;
    sq_pop        = 1'b0;
    sq_rem        = 1'b0;
    key_idx       = idx_r;
    key_dl        = dl_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_ready = 1'b1;
          cmd_nxt   = cmd;
          ret_nxt   = S_IDLE;
          unique case (cmd.op)
            OP_ADD: begin
              if (free_cnt_r != '0) begin
                free_re   = 1'b1;
                state_nxt = S_ADD_IDX;
              end else if (fresh_r < CNT_W'(TIMERS)) begin
                idx_nxt   = fresh_r[IDX_W-1:0];
                fresh_nxt = fresh_r + CNT_W'(1);
                state_nxt = S_ADD_WR;
              end else begin
                res_nxt   = mk_res(ST_FULL);
                state_nxt = S_EMIT;
              end
            end
            OP_DELETE, OP_RESCHED: begin
              if (tid_ok) begin
                rec_re    = 1'b1;
                rec_ra    = tid_ext[IDX_W-1:0];
                idx_nxt   = tid_ext[IDX_W-1:0];
                state_nxt = (cmd.op == OP_DELETE) ? S_DEL : S_RES;
              end else begin
                res_nxt   = mk_res(ST_NO_TIMER);
                state_nxt = S_EMIT;
              end
            end
            OP_ADVANCE: begin
              taken_nxt   = '0;
              nextmin_nxt = TICK_BITS'(cfg.idle_wait);
              state_nxt   = S_ADV;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_IDX: begin
        idx_nxt      = free_rd_r;
        free_cnt_nxt = fc_m1;
        state_nxt    = S_ADD_WR;
      end
      S_ADD_WR: begin
        rec_we     = 1'b1;
        rec_wd.dl  = cmd_r.tick;
        rec_wd.per = cmd_r.interval;
        rec_wd.tag = cmd_r.tag;
        rec_wd.uid = cmd_r.uid;
        rec_wd.ud  = cmd_r.ud;
        sq_ins     = 1'b1;
        key_dl     = cmd_r.tick;
        res_nxt    = mk_res(ST_ADDED);
        res_nxt.id = id_ext[ID_W-1:0];
        state_nxt  = S_EMIT;
      end
      S_DEL: begin
        if (rd_r.tag != cmd_r.tag) begin
          res_nxt = mk_res(ST_MISMATCH);
        end else begin
          rec_we     = 1'b1;
          rec_wd.tag = '0;
          rec_wd.per = '0;
          res_nxt    = mk_res(ST_DELETED);
        end
        state_nxt = S_EMIT;
      end
      S_RES: begin
        key_dl = rd_r.dl;
        if (!sq_found) begin
          res_nxt   = mk_res(ST_NO_TIMER);
          state_nxt = S_EMIT;
        end else begin
          sq_rem    = 1'b1;
          dl_nxt    = rd_r.dl + cmd_r.tick;
          rec_we    = 1'b1;
          rec_wd.dl = rd_r.dl + cmd_r.tick;
          state_nxt = S_RES_INS;
        end
      end
      S_RES_INS: begin
        sq_ins       = 1'b1;
        res_nxt      = mk_res(ST_RESCHED);
        res_nxt.id   = id_ext[ID_W-1:0];
        res_nxt.tick = dl_r;
        state_nxt    = S_EMIT;
      end
      S_ADV: begin
        ret_nxt = S_IDLE;
        if ((sq_cnt == '0) || (taken_r == FIRE_W'(MAX_FIRES))) begin
          res_nxt            = mk_res(ST_WAIT);
          res_nxt.wait_ticks = clamp_wait(nextmin_r, cfg.min_wait);
          state_nxt          = S_EMIT;
        end else if (!diff[TICK_BITS-1] && (diff != '0)) begin
          res_nxt            = mk_res(ST_WAIT);
          res_nxt.wait_ticks = clamp_wait(diff, cfg.min_wait);
          state_nxt          = S_EMIT;
        end else begin
          nextmin_nxt = diff;
          taken_nxt   = taken_r + FIRE_W'(1);
          late_nxt    = late_sum[TICK_BITS];
          sq_pop      = 1'b1;
          rec_re      = 1'b1;
          idx_nxt     = head_idx;
          dl_nxt      = head_dl;
          state_nxt   = S_FIRE;
        end
      end
      S_FIRE: begin
        rep_nxt = late_r ? cmd_r.tick : dl_r;
        if (rd_r.tag != '0) begin
          res_nxt      = '0;
          res_nxt.status = ST_FIRED;
          res_nxt.id   = id_ext[ID_W-1:0];
          res_nxt.tick = late_r ? cmd_r.tick : dl_r;
          res_nxt.tag  = rd_r.tag;
          res_nxt.uid  = rd_r.uid;
          res_nxt.ud   = rd_r.ud;
          ret_nxt      = S_RELOAD;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_RELOAD;
        end
      end
      S_RELOAD: begin
        rec_we = 1'b1;
        if (rd_r.per != '0) begin
          rec_wd.dl = ndl;
          sq_ins    = 1'b1;
          key_dl    = ndl;
        end else begin
          rec_wd.dl  = '0;
          rec_wd.tag = '0;
          rec_wd.per = '0;
          if (free_cnt_r < CNT_W'(TIMERS)) begin
            free_we      = 1'b1;
            free_cnt_nxt = free_cnt_r + CNT_W'(1);
          end
        end
        state_nxt = S_ADV;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ret_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
    if (rec_re) begin
      rd_r <= rec_mem[rec_ra];
    end
    if (free_we) begin
      free_mem[free_wa] <= idx_r;
    end
    if (free_re) begin
      free_rd_r <= free_mem[free_ra];
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    idx_r     <= idx_nxt;
    dl_r      <= dl_nxt;
    rep_r     <= rep_nxt;
    late_r    <= late_nxt;
    nextmin_r <= nextmin_nxt;
    taken_r   <= taken_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      free_cnt_r  <= '0;
      fresh_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      free_cnt_r  <= free_cnt_nxt;
      fresh_r     <= fresh_nxt;
    end
  end

endmodule

>>> verif/tb_sorted_deadline_timer_engine_unit.sv
`timescale 1ns / 1ps
module tb_sorted_deadline_timer_engine_unit;
  import ste_pkg::*;

  class timer_table_scoreboard;
    logic [31:0] deadline [32];
    logic [31:0] period [32];
    logic [15:0] tag [32];
    logic [31:0] ident [32];
    logic [31:0] payload [32];
    int order [32];
    int queued;
    int free_ids [32];
    int free_cnt;
    int fresh;
    logic [15:0] min_wait, catchup, idle_wait;
    res_t pending_results [$];
    int errors;

    function new();
      queued = 0; free_cnt = 0; fresh = 0; errors = 0;
      min_wait = RST_MIN_WAIT; catchup = RST_CATCHUP; idle_wait = RST_IDLE_WAIT;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
      case (idx)
        CFG_MIN_WAIT: min_wait = v;
        CFG_CATCHUP: catchup = v;
        CFG_IDLE_WAIT: idle_wait = v;
        default: ;
      endcase
    endfunction

    function longint tick_diff(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return longint'($signed(d));
    endfunction

    function longint order_key(int a, int b);
      longint x;
      x = tick_diff(deadline[a], deadline[b]);
      return (x == 0) ? longint'(a - b) : x;
    endfunction

    function void enqueue(int idx);
      int pos;
      pos = 0;
      if (queued >= 32) return;
      while (pos < queued && order_key(idx, order[pos]) <= 0) pos++;
      for (int k = queued; k > pos; k--) order[k] = order[k-1];
      order[pos] = idx;
      queued++;
    endfunction

    function bit dequeue(int idx);
      for (int p = 0; p < queued; p++) begin
        if (order[p] == idx) begin
          for (int k = p; k + 1 < queued; k++) order[k] = order[k+1];
          queued--;
          return 1;
        end
      end
      return 0;
    endfunction

    function void push(logic [2:0] st, int id = 0, logic [31:0] tk = 0,
                       logic [15:0] tg = 0, logic [31:0] u = 0, logic [31:0] d = 0,
                       logic [30:0] w = 0, bit lst = 1);
      res_t r;
      r.status = st; r.id = id[4:0]; r.tick = tk; r.tag = tg; r.uid = u; r.ud = d;
      r.wait_ticks = w; r.last = lst;
      pending_results.push_back(r);
    endfunction

    function void note_request(cmd_t c);
      int idx, taken;
      longint nm;
      bit late;
      logic [31:0] base;
      case (c.op)
        OP_ADD: begin
          if (free_cnt > 0) idx = free_ids[--free_cnt];
          else if (fresh < 32) idx = fresh++;
          else begin
            push(ST_FULL);
            return;
          end
          deadline[idx] = c.tick; period[idx] = c.interval; tag[idx] = c.tag;
          ident[idx] = c.uid; payload[idx] = c.ud;
          enqueue(idx);
          push(ST_ADDED, idx);
        end
        OP_DELETE: begin
          if (c.tid >= fresh) push(ST_NO_TIMER);
          else if (tag[c.tid] != c.tag) push(ST_MISMATCH);
          else begin
            tag[c.tid] = 0; period[c.tid] = 0;
            push(ST_DELETED);
          end
        end
        OP_RESCHED: begin
          if (c.tid >= fresh || !dequeue(c.tid)) push(ST_NO_TIMER);
          else begin
            deadline[c.tid] = deadline[c.tid] + c.tick;
            enqueue(c.tid);
            push(ST_RESCHED, c.tid, deadline[c.tid]);
          end
        end
        default: begin
          taken = 0;
          nm = idle_wait;
          while (queued > 0 && taken < 32) begin
            idx = order[queued-1];
            nm = tick_diff(deadline[idx], c.tick);
            if (nm > 0) break;
            queued--;
            taken++;
            late = nm < -longint'(catchup);
            base = late ? c.tick : deadline[idx];
            if (tag[idx] != 0)
              push(ST_FIRED, idx, base, tag[idx], ident[idx], payload[idx], 0, 0);
            if (period[idx] != 0) begin
              deadline[idx] = base + period[idx];
              enqueue(idx);
            end else begin
              tag[idx] = 0; period[idx] = 0; deadline[idx] = 0;
              free_ids[free_cnt++] = idx;
            end
          end
          if (nm < longint'(min_wait)) nm = min_wait;
          if (nm > 64'h7FFF_FFFF) nm = 64'h7FFF_FFFF;
          push(ST_WAIT, 0, 0, 0, 0, 0, nm[30:0], 1);
        end
      endcase
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result status=%0d", a.status);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.id !== e.id) begin
        $error("timer_id_res exp %0d got %0d", e.id, a.id); errors++;
      end
      if (a.tick !== e.tick) begin
        $error("event_tick exp %h got %h", e.tick, a.tick); errors++;
      end
      if (a.tag !== e.tag) begin
        $error("owner_tag_res exp %h got %h", e.tag, a.tag); errors++;
      end
      if (a.uid !== e.uid) begin
        $error("user_id_res exp %h got %h", e.uid, a.uid); errors++;
      end
      if (a.ud !== e.ud) begin
        $error("user_data_res exp %h got %h", e.ud, a.ud); errors++;
      end
      if (a.wait_ticks !== e.wait_ticks) begin
        $error("wait_ticks exp %0d got %0d", e.wait_ticks, a.wait_ticks); errors++;
      end
      if (a.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [ST_W-1:0] out_tuser;
  logic out_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  sorted_deadline_timer_engine_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  timer_table_scoreboard sb = new();
  logic [31:0] now_tick = 0;
  bit quiet = 0;
  bit press_req = 0;
  int idle_cycles = 0;

  // result side: random stalls plus one long hold-off
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    res_t r;
    if (rst_n && out_tvalid && out_tready) begin
      r.status = out_tuser; r.id = out_tdata[4:0]; r.tick = out_tdata[36:5];
      r.tag = out_tdata[52:37]; r.uid = out_tdata[84:53]; r.ud = out_tdata[116:85];
      r.wait_ticks = out_tdata[147:117]; r.last = out_tlast;
      sb.check_result(r);
    end
    if (!rst_n) begin
      out_tready <= 0;
    end else if (press_req && !hold_done) begin
      hold_done <= 1; hold_left <= 400; out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1; out_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1; out_tready <= 0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8); out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_request(cmd_t c);
    in_tvalid <= 1;
    in_tuser <= c.op;
    in_tdata <= {3'b0, c.ud, c.uid, c.tag, c.tid, c.interval, c.tick};
    do @(posedge clk); while (!in_tready);
    sb.note_request(c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic cmd_t make(logic [1:0] op, logic [31:0] tk = 0, logic [31:0] iv = 0,
                                logic [4:0] id = 0, logic [15:0] tg = 0,
                                logic [31:0] u = 0, logic [31:0] d = 0);
    cmd_t c;
    c.op = op; c.tick = tk; c.interval = iv; c.tid = id; c.tag = tg; c.uid = u; c.ud = d;
    return c;
  endfunction

  function automatic cmd_t random_request();
    cmd_t c;
    int pick;
    c = make(OP_ADD, $urandom, $urandom, 5'($urandom_range(0, 31)), 16'($urandom),
             $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c.op = OP_ADD;
      if ($urandom_range(0, 9) != 0) c.tick = now_tick + $urandom_range(0, 3000) - 500;
      case ($urandom_range(0, 3))
        0, 1: c.interval = 0;
        2: c.interval = $urandom_range(1, 2500);
        default: ;
      endcase
      if ($urandom_range(0, 4) == 0) c.tag = 0;
    end else if (pick < 55) begin
      c.op = OP_DELETE;
      if ($urandom_range(0, 2) != 0 && c.tid < sb.fresh) c.tag = sb.tag[c.tid];
    end else if (pick < 70) begin
      c.op = OP_RESCHED;
      if ($urandom_range(0, 4) != 0) c.tick = $urandom_range(0, 4000) - 2000;
    end else begin
      c.op = OP_ADVANCE;
      now_tick = ($urandom_range(0, 19) == 0) ? now_tick + $urandom
                                              : now_tick + $urandom_range(0, 2500);
      c.tick = now_tick;
    end
    return c;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed
    send_request(make(OP_ADVANCE, 0));
    send_request(make(OP_DELETE, 0, 0, 31, 0));
    send_request(make(OP_RESCHED, 5, 0, 0));
    send_request(make(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 16'hFFFF,
                      32'h7FFF_FFFF, 32'h8000_0000));
    send_request(make(OP_ADD, 10, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
    send_request(make(OP_ADD, 10, 100, 0, 16'h1234, 32'hFFFF_FFFF, 0));
    send_request(make(OP_DELETE, 0, 0, 0, 16'h0001));
    send_request(make(OP_RESCHED, 32'hFFFF_FFF0, 0, 2));
    send_request(make(OP_ADVANCE, 5000));
    send_request(make(OP_DELETE, 0, 0, 1, 0));
    send_request(make(OP_DELETE, 0, 0, 0, 16'hFFFF));
    send_request(make(OP_ADVANCE, 32'h8000_0000));
    for (int i = 0; i < 33; i++)
      send_request(make(OP_ADD, i % 3, 1, 0, i[15:0], i, -i));
    send_request(make(OP_ADVANCE, 2));
    send_request(make(OP_ADVANCE, 4000));
    now_tick = 4000;
    drain();

    write_reg(CFG_MIN_WAIT, 0);
    write_reg(CFG_CATCHUP, 0);
    write_reg(CFG_IDLE_WAIT, 0);
    for (int i = 0; i < 90; i++) send_request(random_request());
    drain();

    write_reg(CFG_MIN_WAIT, 16'hFFFF);
    write_reg(CFG_CATCHUP, 16'hFFFF);
    write_reg(CFG_IDLE_WAIT, 16'hFFFF);
    press_req <= 1;
    for (int i = 0; i < 90; i++) send_request(random_request());
    drain();

    write_reg(CFG_MIN_WAIT, 16'($urandom));
    write_reg(CFG_CATCHUP, 16'($urandom_range(0, 3000)));
    write_reg(CFG_IDLE_WAIT, 16'($urandom));
    for (int i = 0; i < 70; i++) send_request(random_request());
    quiet = 1;
    for (int i = 0; i < 60; i++) send_request(random_request());
    in_tvalid <= 0;

    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
